// File: hw/rtl/cbte_pkg.sv
// Shared types and constants for the cubic Bezier triangle evaluator.
// Holds the Bernstein weight selection table and the stage enable bundle.
// No dependencies.
package cbte_pkg;

   localparam int NUM_POINTS = 10;
   localparam int NUM_AXES   = 3;

   // Item command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // One Bernstein weight: b[s0] * b[s1] * b[s2] * factor
   typedef struct packed {
      logic [1:0] s0;
      logic [1:0] s1;
      logic [1:0] s2;
      logic [2:0] factor;
   } cbte_wsel_type;

   localparam cbte_wsel_type WSEL [NUM_POINTS] = '{
      '{2'd0, 2'd0, 2'd0, 3'd1},
      '{2'd1, 2'd1, 2'd1, 3'd1},
      '{2'd2, 2'd2, 2'd2, 3'd1},
      '{2'd0, 2'd0, 2'd1, 3'd3},
      '{2'd0, 2'd1, 2'd1, 3'd3},
      '{2'd1, 2'd1, 2'd2, 3'd3},
      '{2'd1, 2'd2, 2'd2, 3'd3},
      '{2'd0, 2'd2, 2'd2, 3'd3},
      '{2'd0, 2'd0, 2'd2, 3'd3},
      '{2'd0, 2'd1, 2'd2, 3'd6}
   };

   // Load enables of the weight pipeline registers
   typedef struct packed {
      logic pq;
      logic part;
      logic wgt;
   } cbte_stage_en_type;

endpackage

// File: hw/rtl/cubic_bezier_triangle_eval_top.sv
// Top level of the cubic Bezier triangle evaluator: input stage, control point
// store, coordinate products, adder tree and saturation. Uses cbte_pkg and cbte_weights.
//
// Usage:
//   req_* channel carries one transaction per item. cmd 0 loads control point
//   req_point_index (0..9, others ignored) with req_load_x/y/z; cmd 1 evaluates
//   the surface at req_bary0/1/2. Only evaluates produce a rsp_* transaction.
//   Loads take effect in item order: an evaluate sees every load sent before it
//   and none sent after it.
//   Pipeline: nine register stages, the last being the output register.
//   Throughput: one item per cycle while rsp_ready holds high, set by the
//   fully pipelined multipliers; stages advance independently, so bubbles
//   close up.
//   Stall: when rsp_ready is low the result holds on rsp_*; the pipeline keeps
//   accepting until all nine stages hold an item, then req_ready drops.
//   Reset (synchronous): clears all stage valids and sets every stored control
//   point to zero; the block is ready on the first cycle after reset.
module cubic_bezier_triangle_eval_top #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [3:0]                     req_point_index,
   input  logic signed [COORD_BITS-1:0]   req_load_x,
   input  logic signed [COORD_BITS-1:0]   req_load_y,
   input  logic signed [COORD_BITS-1:0]   req_load_z,
   input  logic signed [FRAC_BITS+1:0]    req_bary0,
   input  logic signed [FRAC_BITS+1:0]    req_bary1,
   input  logic signed [FRAC_BITS+1:0]    req_bary2,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [COORD_BITS-1:0]   rsp_surface_x,
   output logic signed [COORD_BITS-1:0]   rsp_surface_y,
   output logic signed [COORD_BITS-1:0]   rsp_surface_z,
   output logic                           rsp_saturated
);
   import cbte_pkg::*;

   localparam int CB         = COORD_BITS;
   localparam int BB         = FRAC_BITS + 2;
   localparam int WB         = 2 * FRAC_BITS + 10;   // weight width, Q.2F
   localparam int L          = WB / 2;               // split point of weight
   localparam int MLW        = L + 1 + CB;
   localparam int MHW        = (WB - L) + CB;
   localparam int AW         = WB + CB + 5;          // exact Q.3F accumulator
   localparam int RW         = AW - 2 * FRAC_BITS;   // rounded Q.F sum
   localparam int NUM_GROUPS = 3;
   localparam int LAST       = 8;                    // last internal stage

   localparam logic [AW-1:0] SUM_RND = AW'(1) << (2 * FRAC_BITS - 1);
   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

   // Stage valids and load enables (stage LAST+1 is the output register)
   logic [LAST:1]   vld_ff;
   logic [LAST:1]   vld_in;
   logic            rsp_valid_ff;
   logic [LAST+1:1] en;

   // Item payload, stages 1 to 4
   logic                 cmd_ff  [1:4];
   logic [3:0]           idx_ff  [1:4];
   logic signed [CB-1:0] ld_ff   [1:4][NUM_AXES];
   logic signed [BB-1:0] bary_ff [NUM_AXES];

   cbte_stage_en_type    wgt_en;
   logic signed [WB-1:0] weight [NUM_POINTS];

   // Control point store
   logic signed [CB-1:0] store_ff [NUM_POINTS][NUM_AXES];
   logic                 store_we;

   // Datapath stages 5 to 8 and output
   logic signed [MLW-1:0] ml_in  [NUM_POINTS][NUM_AXES];
   logic signed [MHW-1:0] mh_in  [NUM_POINTS][NUM_AXES];
   logic signed [MLW-1:0] ml_ff  [NUM_POINTS][NUM_AXES];
   logic signed [MHW-1:0] mh_ff  [NUM_POINTS][NUM_AXES];
   logic signed [AW-1:0]  term_in [NUM_AXES][NUM_POINTS];
   logic signed [AW-1:0]  term_ff [NUM_AXES][NUM_POINTS];
   logic signed [AW-1:0]  grp_in  [NUM_AXES][NUM_GROUPS];
   logic signed [AW-1:0]  grp_ff  [NUM_AXES][NUM_GROUPS];
   logic signed [AW-1:0]  sum_in  [NUM_AXES];
   logic signed [AW-1:0]  sum_ff  [NUM_AXES];
   logic signed [RW-1:0]  rnd     [NUM_AXES];
   logic signed [CB-1:0]  surf_in [NUM_AXES];
   logic signed [CB-1:0]  surf_ff [NUM_AXES];
   logic                  sat_in;
   logic                  sat_ff;

   // Stage enables: a stage loads when empty or when its item moves on
   always_comb begin
      en[LAST+1] = !rsp_valid_ff || rsp_ready;
      for (int i = LAST; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[1];

   // Valid bits travel with the data; loads retire after the store write
   always_comb begin
      vld_in[1] = req_valid;
      for (int i = 2; i <= LAST; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
      vld_in[5] = vld_ff[4] && (cmd_ff[4] == CMD_EVAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 1; i <= LAST; i++) begin
            if (en[i]) vld_ff[i] <= vld_in[i];
         end
         if (en[LAST+1]) rsp_valid_ff <= vld_ff[LAST];
      end
   end

   // Input stage and payload carried to the store write stage
   always_ff @(posedge clock) begin
      if (en[1]) begin
         cmd_ff[1]   <= req_cmd;
         idx_ff[1]   <= req_point_index;
         ld_ff[1][0] <= req_load_x;
         ld_ff[1][1] <= req_load_y;
         ld_ff[1][2] <= req_load_z;
         bary_ff[0]  <= req_bary0;
         bary_ff[1]  <= req_bary1;
         bary_ff[2]  <= req_bary2;
      end
      for (int i = 2; i <= 4; i++) begin
         if (en[i]) begin
            cmd_ff[i] <= cmd_ff[i-1];
            idx_ff[i] <= idx_ff[i-1];
            ld_ff[i]  <= ld_ff[i-1];
         end
      end
   end

   // Weight pipeline, stages 2 to 4
   assign wgt_en = '{pq: en[2], part: en[3], wgt: en[4]};

   cbte_weights #(
      .FRAC_BITS (FRAC_BITS)
   ) u_weights (
      .clock    (clock),
      .stage_en (wgt_en),
      .bary     (bary_ff),
      .weight   (weight)
   );

   // Store write as a load leaves stage 4, in order with evaluates reading it
   assign store_we = vld_ff[4] && (cmd_ff[4] == CMD_LOAD) && en[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_POINTS; k++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
               store_ff[k][c] <= '0;
            end
         end
      end else if (store_we) begin
         for (int k = 0; k < NUM_POINTS; k++) begin
            if (idx_ff[4] == 4'(k)) store_ff[k] <= ld_ff[4];
         end
      end
   end

   // Stage 5: weight halves times coordinates
   always_comb begin
      for (int k = 0; k < NUM_POINTS; k++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            ml_in[k][c] = MLW'($signed({1'b0, weight[k][L-1:0]})) * MLW'(store_ff[k][c]);
            mh_in[k][c] = MHW'($signed(weight[k][WB-1:L])) * MHW'(store_ff[k][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         ml_ff <= ml_in;
         mh_ff <= mh_in;
      end
   end

   // Stage 6: recombine partial products into full terms
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         for (int k = 0; k < NUM_POINTS; k++) begin
            term_in[c][k] = (AW'(mh_ff[k][c]) <<< L) + AW'(ml_ff[k][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) term_ff <= term_in;
   end

   // Stage 7: first level of the adder tree, three groups per axis
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_in[c][g] = '0;
         end
         for (int k = 0; k < NUM_POINTS; k++) begin
            grp_in[c][2'(k % NUM_GROUPS)] = grp_in[c][2'(k % NUM_GROUPS)] + term_ff[c][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) grp_ff <= grp_in;
   end

   // Stage 8: final sum plus rounding constant
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         sum_in[c] = grp_ff[c][0] + grp_ff[c][1] + grp_ff[c][2] + $signed(SUM_RND);
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) sum_ff <= sum_in;
   end

   // Output stage: drop 2F fraction bits and saturate
   always_comb begin
      sat_in = 1'b0;
      for (int c = 0; c < NUM_AXES; c++) begin
         rnd[c] = sum_ff[c][AW-1:2*FRAC_BITS];
         if ((rnd[c][RW-1:CB-1] == '0) || (rnd[c][RW-1:CB-1] == '1)) begin
            surf_in[c] = rnd[c][CB-1:0];
         end else begin
            surf_in[c] = rnd[c][RW-1] ? COORD_MIN : COORD_MAX;
            sat_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST+1]) begin
         surf_ff <= surf_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_surface_x = surf_ff[0];
   assign rsp_surface_y = surf_ff[1];
   assign rsp_surface_z = surf_ff[2];
   assign rsp_saturated = sat_ff;

   // Input is refused only when every stage holds an item
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&vld_ff) && rsp_valid_ff))
      else $error("req_ready low with a free pipeline stage");

   // A saturated result has at least one coordinate at a range limit
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |->
         (surf_ff[0] == COORD_MAX || surf_ff[0] == COORD_MIN ||
          surf_ff[1] == COORD_MAX || surf_ff[1] == COORD_MIN ||
          surf_ff[2] == COORD_MAX || surf_ff[2] == COORD_MIN))
      else $error("saturated flag without a clipped coordinate");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && (vld_ff == '0)))
      else $error("pipeline not empty after reset");

   // A load of point 0 leaving stage 4 lands in the store (x axis checked)
   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      (store_we && (idx_ff[4] == 4'd0)) |=> (store_ff[0][0] == $past(ld_ff[4][0])))
      else $error("load did not reach the control point store");

   // A stalled item in the last stage is held
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST] && !en[LAST+1]) |=> vld_ff[LAST])
      else $error("stalled item lost from last stage");

endmodule

// File: hw/rtl/cbte_weights.sv
// Three-stage pipeline forming the ten Bernstein weights in Q.2F.
// Depends on cbte_pkg (weight table, stage enable struct).
module cbte_weights #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  cbte_pkg::cbte_stage_en_type       stage_en,
   input  logic signed [FRAC_BITS+1:0]       bary [cbte_pkg::NUM_AXES],
   output logic signed [2*FRAC_BITS+9:0]     weight [cbte_pkg::NUM_POINTS]
);
   import cbte_pkg::*;

   localparam int BB  = FRAC_BITS + 2;     // barycentric width
   localparam int PW  = 2 * BB;            // b*b product
   localparam int QW  = BB + 3;            // b*factor
   localparam int H   = BB;                // split point of b*b
   localparam int PLW = H + 1 + QW;        // low partial
   localparam int PHW = (PW - H) + QW;     // high partial
   localparam int TW  = PW + QW + 1;       // exact Q.3F weight
   localparam int WB  = TW - FRAC_BITS;    // Q.2F weight

   localparam logic [TW-1:0] WRND = TW'(1) << (FRAC_BITS - 1);

   logic signed [PW-1:0]  p_in  [NUM_POINTS];
   logic signed [QW-1:0]  q_in  [NUM_POINTS];
   logic signed [PW-1:0]  p_ff  [NUM_POINTS];
   logic signed [QW-1:0]  q_ff  [NUM_POINTS];
   logic signed [PLW-1:0] pl_in [NUM_POINTS];
   logic signed [PHW-1:0] ph_in [NUM_POINTS];
   logic signed [PLW-1:0] pl_ff [NUM_POINTS];
   logic signed [PHW-1:0] ph_ff [NUM_POINTS];
   logic signed [TW-1:0]  t_sum [NUM_POINTS];
   logic signed [WB-1:0]  wgt_in [NUM_POINTS];
   logic signed [WB-1:0]  wgt_ff [NUM_POINTS];

   // Stage 1: pair product and scaled third factor
   always_comb begin
      for (int k = 0; k < NUM_POINTS; k++) begin
         p_in[k] = PW'(bary[WSEL[k].s0]) * PW'(bary[WSEL[k].s1]);
         q_in[k] = QW'(bary[WSEL[k].s2]) * QW'($signed({1'b0, WSEL[k].factor}));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.pq) begin
         p_ff <= p_in;
         q_ff <= q_in;
      end
   end

   // Stage 2: split b*b into halves, two narrow partial products
   always_comb begin
      for (int k = 0; k < NUM_POINTS; k++) begin
         pl_in[k] = PLW'($signed({1'b0, p_ff[k][H-1:0]})) * PLW'(q_ff[k]);
         ph_in[k] = PHW'($signed(p_ff[k][PW-1:H])) * PHW'(q_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.part) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
      end
   end

   // Stage 3: recombine, round half up and drop F fraction bits
   always_comb begin
      for (int k = 0; k < NUM_POINTS; k++) begin
         t_sum[k]  = (TW'(ph_ff[k]) <<< H) + TW'(pl_ff[k]) + $signed(WRND);
         wgt_in[k] = t_sum[k][TW-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.wgt) begin
         wgt_ff <= wgt_in;
      end
   end

   assign weight = wgt_ff;

endmodule
